[sv/tbba_pkg.sv]
// ----------------------------------------------------------------------------
// tbba_pkg
// Constants, codes and helpers for the two-region bitmap block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package tbba_pkg;

  // Disk geometry
  localparam int unsigned TOTAL_BLOCKS = 4096;
  localparam int unsigned FIRST_DATA   = 256;
  localparam int unsigned FIRST_INODE  = 3;
  localparam int unsigned RSVD_BLOCKS  = 3;   // superblock, bitmap, root inode

  // Map layout: 64-bit memory words
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned BIT_W     = $clog2(WORD_BITS);
  localparam int unsigned WORDS     = (TOTAL_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WADDR_W   = $clog2(WORDS);

  // Field widths
  localparam int unsigned MODE_W = 2;
  localparam int unsigned NUM_W  = 12;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned IN_TDATA_W  = ((MODE_W + NUM_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((STAT_W + NUM_W + 7) / 8) * 8;

  // Region bounds [lo, hi), clamped to the map
  localparam int unsigned INO_LO = FIRST_INODE;
  localparam int unsigned INO_HI = (FIRST_DATA < TOTAL_BLOCKS) ? FIRST_DATA : TOTAL_BLOCKS;
  localparam int unsigned DAT_LO = FIRST_DATA;
  localparam int unsigned DAT_HI = TOTAL_BLOCKS;
  localparam bit INO_EMPTY = (INO_HI <= INO_LO);
  localparam bit DAT_EMPTY = (DAT_HI <= DAT_LO);
  localparam int unsigned INO_W0 = INO_EMPTY ? 0 : INO_LO / WORD_BITS;
  localparam int unsigned INO_WN = INO_EMPTY ? 0 : (INO_HI - 1) / WORD_BITS;
  localparam int unsigned DAT_W0 = DAT_EMPTY ? 0 : DAT_LO / WORD_BITS;
  localparam int unsigned DAT_WN = DAT_EMPTY ? 0 : (DAT_HI - 1) / WORD_BITS;

  // Request codes
  localparam logic [MODE_W-1:0] MODE_ALLOC_INO = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE_INO  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ALLOC_DAT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FREE_DAT  = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

  // Map word after reset: reserved blocks marked used
  function automatic logic [WORD_BITS-1:0] reset_word(input logic [WADDR_W-1:0] w);
    logic [WORD_BITS-1:0] r;
    int unsigned blk;
    r = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      blk  = int'(w) * WORD_BITS + b;
      r[b] = (blk < RSVD_BLOCKS);
    end
    return r;
  endfunction

  // Bits of word w that lie outside [lo, hi): treated as used by the scan
  function automatic logic [WORD_BITS-1:0] outside_mask(input logic [WADDR_W-1:0] w,
                                                        input int unsigned lo,
                                                        input int unsigned hi);
    logic [WORD_BITS-1:0] m;
    int unsigned blk;
    m = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      blk  = int'(w) * WORD_BITS + b;
      m[b] = (blk < lo) || (blk >= hi);
    end
    return m;
  endfunction

  // Position of the lowest clear bit
  function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] p;
    p = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!v[b]) p = BIT_W'(b);
    end
    return p;
  endfunction

endpackage

`default_nettype wire

[sv/two_region_bitmap_block_allocator.sv]
// ----------------------------------------------------------------------------
// two_region_bitmap_block_allocator
// First-fit allocator over a used/free bitmap split into inode and data regions.
// ----------------------------------------------------------------------------
// Sequencing: a free reads, then rewrites, one map word; an out-of-range free goes
//   straight to the result; an allocate scans the region's 64-bit map words in order
//   (words 4 to 63 for data, 0 to 3 for inode), stopping at the first with a clear bit.
// Throughput: one request at a time; the next is taken once the result has gone into
//   the output register, later while the result word is stalled.
// Reset: async, active low; per-row valid bits read unwritten rows as reserved-only.
// ----------------------------------------------------------------------------
`default_nettype none

module two_region_bitmap_block_allocator
  import tbba_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // request: [1:0] mode, [13:2] block_number_in, [15:14] zero
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // result: [1:0] status, [13:2] block_number_out, [15:14] zero
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;   // word from RAM under test each cycle
  localparam logic [1:0] S_FREE = 2'd2;   // clear one bit of the read word
  localparam logic [1:0] S_OUT  = 2'd3;   // hand result to output register

  logic [1:0]           state_q, state_d;
  logic                 inode_q, inode_d;     // region of the running scan
  logic [NUM_W-1:0]     idx_q, idx_d;
  logic [WADDR_W-1:0]   addr_q, addr_d;       // next word to read in a scan
  logic [STAT_W-1:0]    res_st_q, res_st_d;
  logic [NUM_W-1:0]     res_num_q, res_num_d;

  logic                 m_vld_q, m_vld_d;
  logic [STAT_W-1:0]    m_st_q, m_st_d;
  logic [NUM_W-1:0]     m_num_q, m_num_d;

  // Map RAM, one word per row, plus a valid bit per row
  logic [WORD_BITS-1:0] mem_q [WORDS];
  logic [WORDS-1:0]     row_vld_q, row_vld_d;
  logic                 rd_en;
  logic [WADDR_W-1:0]   rd_addr;
  logic [WORD_BITS-1:0] rd_data_q;
  logic                 rd_vld_q;
  logic [WADDR_W-1:0]   rd_addr_q;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_data;

  // Request fields
  logic [MODE_W-1:0]    req_mode;
  logic [NUM_W-1:0]     req_num;
  logic                 req_in_map;
  logic                 accept;

  // Scan datapath
  logic [WORD_BITS-1:0] cur_word;
  logic [WORD_BITS-1:0] masked;
  logic [BIT_W-1:0]     hit_bit;
  logic                 hit;
  logic                 last_word;
  logic [BIT_W-1:0]     free_bit;

  assign req_mode   = s_axis_tdata[MODE_W-1:0];
  assign req_num    = s_axis_tdata[MODE_W +: NUM_W];
  assign req_in_map = (32'(req_num) < TOTAL_BLOCKS);

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Word as it stands in the map; unwritten rows read as reset value
  assign cur_word = rd_vld_q ? rd_data_q : reset_word(rd_addr_q);

  assign masked    = inode_q ? (cur_word | outside_mask(rd_addr_q, INO_LO, INO_HI))
                             : (cur_word | outside_mask(rd_addr_q, DAT_LO, DAT_HI));
  assign hit       = ~&masked;
  assign hit_bit   = first_zero(masked);
  assign last_word = inode_q ? (rd_addr_q == WADDR_W'(INO_WN))
                             : (rd_addr_q == WADDR_W'(DAT_WN));
  assign free_bit  = idx_q[BIT_W-1:0];

  always_comb begin
    state_d   = state_q;
    inode_d   = inode_q;
    idx_d     = idx_q;
    addr_d    = addr_q;
    res_st_d  = res_st_q;
    res_num_d = res_num_q;
    rd_en     = 1'b0;
    rd_addr   = addr_q;
    wr_en     = 1'b0;
    wr_data   = cur_word;
    row_vld_d = row_vld_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d     = req_num;
          res_st_d  = ST_OK;
          res_num_d = '0;
          case (req_mode)
            MODE_ALLOC_INO, MODE_ALLOC_DAT: begin
              inode_d = (req_mode == MODE_ALLOC_INO);
              if ((req_mode == MODE_ALLOC_INO) ? INO_EMPTY : DAT_EMPTY) begin
                res_st_d = ST_FULL;
                state_d  = S_OUT;
              end else begin
                rd_en   = 1'b1;
                rd_addr = (req_mode == MODE_ALLOC_INO) ? WADDR_W'(INO_W0)
                                                       : WADDR_W'(DAT_W0);
                addr_d  = rd_addr + 1'b1;
                state_d = S_SCAN;
              end
            end
            MODE_FREE_INO: begin
              // any index; one past the map is a silent no-op
              if (req_in_map) begin
                rd_en   = 1'b1;
                rd_addr = WADDR_W'(req_num >> BIT_W);
                state_d = S_FREE;
              end else begin
                state_d = S_OUT;
              end
            end
            default: begin
              // free data: only inside the data region
              if (req_in_map && (32'(req_num) >= FIRST_DATA)) begin
                rd_en   = 1'b1;
                rd_addr = WADDR_W'(req_num >> BIT_W);
                state_d = S_FREE;
              end else begin
                res_st_d = ST_BAD;
                state_d  = S_OUT;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        // keep the read pipe full; an extra read after a hit is dropped
        rd_en  = 1'b1;
        addr_d = addr_q + 1'b1;
        if (hit) begin
          wr_en                = 1'b1;
          wr_data              = cur_word | (WORD_BITS'(1) << hit_bit);
          row_vld_d[rd_addr_q] = 1'b1;
          res_st_d             = ST_OK;
          res_num_d            = NUM_W'({rd_addr_q, hit_bit});
          state_d              = S_OUT;
        end else if (last_word) begin
          res_st_d = ST_FULL;
          state_d  = S_OUT;
        end
      end

      S_FREE: begin
        wr_en                = 1'b1;
        wr_data              = cur_word & ~(WORD_BITS'(1) << free_bit);
        row_vld_d[rd_addr_q] = 1'b1;
        state_d              = S_OUT;
      end

      default: begin
        if (!m_vld_q || m_axis_tready) state_d = S_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    m_vld_d = m_vld_q;
    m_st_d  = m_st_q;
    m_num_d = m_num_q;
    if (m_vld_q && m_axis_tready) m_vld_d = 1'b0;
    if ((state_q == S_OUT) && (!m_vld_q || m_axis_tready)) begin
      m_vld_d = 1'b1;
      m_st_d  = res_st_q;
      m_num_d = res_num_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_vld_q   <= 1'b0;
      row_vld_q <= '0;
    end else begin
      state_q   <= state_d;
      m_vld_q   <= m_vld_d;
      row_vld_q <= row_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inode_q   <= inode_d;
    idx_q     <= idx_d;
    addr_q    <= addr_d;
    res_st_q  <= res_st_d;
    res_num_q <= res_num_d;
    m_st_q    <= m_st_d;
    m_num_q   <= m_num_d;
  end

  // Map RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[rd_addr_q] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_vld_q  <= row_vld_q[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = OUT_TDATA_W'({m_num_q, m_st_q});

endmodule

`default_nettype wire

[test/tb_two_region_bitmap_block_allocator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_region_bitmap_block_allocator
// Self-checking bench for the two-region bitmap block allocator. A scoreboard
// class keeps its own copy of the used/free map, predicts status and block
// number for every accepted request and compares each result word in order.
// The stimulus is a short directed list followed by random episodes: inode
// fill and release, data churn, bad frees, mixed noise and a long data burst.
// ----------------------------------------------------------------------------

module tb_two_region_bitmap_block_allocator
  import tbba_pkg::*;
();

  // Expected result of one request
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [NUM_W-1:0]  number;
  } alloc_result_t;

  // Kinds of random episode
  typedef enum int {
    EP_MIXED,
    EP_INODE_CYCLE,
    EP_DATA_CHURN,
    EP_BAD_FREES
  } episode_e;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow map, expected results in request order
  // --------------------------------------------------------------------------
  class block_map_scoreboard;
    bit            disk_map [TOTAL_BLOCKS];
    alloc_result_t pending_results [$];
    int unsigned   errors;
    int unsigned   results_seen;

    function new();
      foreach (disk_map[i]) disk_map[i] = (i < RSVD_BLOCKS);
      errors       = 0;
      results_seen = 0;
    endfunction

    // Lowest clear bit in [lo, hi), hi clamped to the disk
    function bit lowest_free(input int unsigned lo, input int unsigned hi,
                             output int unsigned at);
      int unsigned top;
      top = (hi > TOTAL_BLOCKS) ? TOTAL_BLOCKS : hi;
      at  = 0;
      for (int unsigned i = lo; i < top; i++) begin
        if (!disk_map[i]) begin
          at = i;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // Apply one accepted request to the shadow map and queue its result
    function void note_request(input logic [MODE_W-1:0] mode,
                               input logic [NUM_W-1:0] idx);
      alloc_result_t r;
      int unsigned   at;
      r.status = ST_OK;
      r.number = '0;
      case (mode)
        MODE_ALLOC_INO, MODE_ALLOC_DAT: begin
          if (lowest_free((mode == MODE_ALLOC_INO) ? FIRST_INODE : FIRST_DATA,
                          (mode == MODE_ALLOC_INO) ? FIRST_DATA : TOTAL_BLOCKS, at)) begin
            disk_map[at] = 1'b1;
            r.number     = NUM_W'(at);
          end else begin
            r.status = ST_FULL;
          end
        end
        MODE_FREE_INO: begin
          // no range check; an index past the disk is a no-op
          if (idx < TOTAL_BLOCKS) disk_map[idx] = 1'b0;
        end
        default: begin
          if (idx < FIRST_DATA || idx >= TOTAL_BLOCKS) r.status = ST_BAD;
          else disk_map[idx] = 1'b0;
        end
      endcase
      pending_results.push_back(r);
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    // One line per mismatch
    task report(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(input logic [OUT_TDATA_W-1:0] word);
      alloc_result_t     want;
      logic [STAT_W-1:0] st;
      logic [NUM_W-1:0]  num;
      st = word[STAT_W-1:0];
      num = word[STAT_W +: NUM_W];
      results_seen++;
      if (pending_results.size() == 0) begin
        report($sformatf("result %0d with nothing pending (status %0d, block %0d)",
                         results_seen, st, num));
      end else begin
        want = pending_results.pop_front();
        if (st !== want.status)
          report($sformatf("result %0d status %0d, expected %0d",
                           results_seen, st, want.status));
        if (num !== want.number)
          report($sformatf("result %0d block %0d, expected %0d",
                           results_seen, num, want.number));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, bus signals
  // --------------------------------------------------------------------------
  logic                   clk      = 1'b0;
  logic                   rst_n    = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   m_tready = 1'b0;
  wire                    s_axis_tready;
  wire                    m_axis_tvalid;
  wire [OUT_TDATA_W-1:0]  m_axis_tdata;

  block_map_scoreboard sb;
  bit                  src_idle_on  = 1'b0;  // sender may insert gaps
  bit                  sink_idle_on = 1'b0;  // receiver may stall
  int unsigned         sent_count   = 0;

  always #6 clk = ~clk;

  two_region_bitmap_block_allocator dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),        // [1:0] mode, [13:2] block_number_in
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata)    // [1:0] status, [13:2] block_number_out
  );

  // Mostly back-to-back, sometimes a short gap, rarely a long pause
  function automatic int unsigned pick_gap(input bit on);
    int unsigned r;
    if (!on) return 0;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // An index near a region boundary, or anywhere on the disk
  function automatic logic [NUM_W-1:0] boundary_index();
    case ($urandom_range(7, 0))
      0: return NUM_W'($urandom_range(RSVD_BLOCKS, 0));
      1: return NUM_W'($urandom_range(FIRST_DATA + 1, FIRST_DATA - 2));
      2: return {NUM_W{1'b1}};
      default: return NUM_W'($urandom);
    endcase
  endfunction

  // Prefer a block that is in use, so frees actually change the map
  function automatic logic [NUM_W-1:0] pick_used(input int unsigned lo,
                                                 input int unsigned hi);
    int unsigned n;
    n = lo;
    for (int t = 0; t < 16; t++) begin
      n = $urandom_range(hi - 1, lo);
      if (sb.disk_map[n]) return NUM_W'(n);
    end
    return NUM_W'(n);
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: called at a falling edge, returns at a falling edge.
  // tvalid is lowered only when a gap follows, so a back-to-back word never
  // sees a low and a high assignment in one step.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [MODE_W-1:0] mode,
                              input logic [NUM_W-1:0] idx);
    int unsigned gap;
    gap = pick_gap(src_idle_on);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= IN_TDATA_W'($urandom);   // junk while idle
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'({idx, mode});
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(mode, idx);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic alloc_until_full(input logic [MODE_W-1:0] mode,
                                  input int unsigned lo, input int unsigned hi);
    int unsigned at;
    while (sb.lowest_free(lo, hi, at)) send_request(mode, boundary_index());
    // a few more to see the no-space answer
    repeat ($urandom_range(3, 1)) send_request(mode, boundary_index());
  endtask

  task automatic run_episode(input episode_e kind);
    int unsigned n;
    n = 0;
    src_idle_on  = ($urandom_range(3, 0) != 0);
    sink_idle_on = ($urandom_range(3, 0) != 0);
    case (kind)
      EP_MIXED: begin
        repeat ($urandom_range(30, 10))
          send_request(MODE_W'($urandom_range(3, 0)), boundary_index());
      end
      EP_INODE_CYCLE: begin
        alloc_until_full(MODE_ALLOC_INO, FIRST_INODE, FIRST_DATA);
        repeat ($urandom_range(40, 1)) send_request(MODE_FREE_INO,
                                                   pick_used(FIRST_INODE, FIRST_DATA));
      end
      EP_DATA_CHURN: begin
        n = $urandom_range(40, 5);
        repeat (n) begin
          if ($urandom_range(9, 0) < 6) send_request(MODE_ALLOC_DAT, NUM_W'($urandom));
          else if ($urandom_range(3, 0) != 0)
            send_request(MODE_FREE_DAT, pick_used(FIRST_DATA, TOTAL_BLOCKS));
          else
            send_request(MODE_FREE_INO, pick_used(FIRST_DATA, TOTAL_BLOCKS));
        end
      end
      default: begin
        // frees that must be refused, and free-inode on reserved blocks
        repeat ($urandom_range(10, 3)) begin
          if ($urandom_range(1, 0) != 0)
            send_request(MODE_FREE_DAT, NUM_W'($urandom_range(FIRST_DATA - 1, 0)));
          else
            send_request(MODE_FREE_INO, NUM_W'($urandom_range(RSVD_BLOCKS - 1, 0)));
        end
      end
    endcase
  endtask

  task automatic random_phase(input int unsigned upto);
    int unsigned r;
    while (sent_count < upto) begin
      r = $urandom_range(99, 0);
      if (r < 30) run_episode(EP_MIXED);
      else if (r < 45) run_episode(EP_INODE_CYCLE);
      else if (r < 85) run_episode(EP_DATA_CHURN);
      else run_episode(EP_BAD_FREES);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls on tready, checking at the rising edge
  // --------------------------------------------------------------------------
  initial begin : sink_side
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        m_tready <= 1'b1;
        hold = pick_gap(sink_idle_on);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && m_axis_tvalid && m_tready) sb.check_result(m_axis_tdata);
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned base;
    sb = new();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: first fit in both regions, reserved and cross-region frees,
    // refused data frees, double frees, field extremes
    send_request(MODE_ALLOC_INO, '0);                 // -> 3
    send_request(MODE_ALLOC_DAT, {NUM_W{1'b1}});      // -> 256
    send_request(MODE_FREE_INO, NUM_W'(0));           // reserved block, ok
    send_request(MODE_ALLOC_INO, '0);                 // block 0 not in region -> 4
    send_request(MODE_FREE_INO, {NUM_W{1'b1}});       // data block via free-inode
    send_request(MODE_FREE_INO, NUM_W'(FIRST_INODE));
    send_request(MODE_FREE_INO, NUM_W'(FIRST_INODE)); // already free
    send_request(MODE_ALLOC_INO, '0);                 // -> 3 again
    send_request(MODE_FREE_DAT, NUM_W'(FIRST_DATA - 1));
    send_request(MODE_FREE_DAT, NUM_W'(0));
    send_request(MODE_FREE_DAT, {NUM_W{1'b1}});       // free of a free data block
    send_request(MODE_FREE_DAT, NUM_W'(FIRST_DATA));
    send_request(MODE_FREE_DAT, NUM_W'(FIRST_DATA));
    send_request(MODE_ALLOC_DAT, '0);                 // -> 256
    send_request(MODE_FREE_INO, NUM_W'(FIRST_DATA));
    send_request(MODE_ALLOC_DAT, '0);
    send_request(MODE_ALLOC_DAT, 12'h555);
    send_request(MODE_FREE_DAT, 12'h555);
    send_request(MODE_FREE_DAT, 12'hAAA);
    send_request(MODE_FREE_INO, 12'h555);
    send_request(MODE_FREE_INO, NUM_W'(1));
    send_request(MODE_FREE_INO, NUM_W'(2));
    send_request(MODE_ALLOC_INO, 12'hAAA);

    base = sent_count;
    random_phase(base + 780);

    // Long run of data allocations under gaps and stalls, then release part of it
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    repeat (60) send_request(MODE_ALLOC_DAT, boundary_index());
    send_request(MODE_ALLOC_INO, '0);
    repeat (40) send_request(MODE_FREE_DAT, pick_used(FIRST_DATA, TOTAL_BLOCKS));

    base = sent_count;
    random_phase(base + 760);

    s_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    // catch any stray late word
    repeat (80) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run with every gap and stall long
  initial begin : watchdog
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[sim.f]
sv/tbba_pkg.sv
sv/two_region_bitmap_block_allocator.sv
test/tb_two_region_bitmap_block_allocator.sv
